>>> rtl/luma_difference_edge_detector_defines.svh
// assertion macros for the luma difference edge detector
`ifndef LUMA_DIFFERENCE_EDGE_DETECTOR_DEFINES_SVH
`define LUMA_DIFFERENCE_EDGE_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define LDE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lde assertion failed");

// next-cycle implication, checked out of reset
`define LDE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lde assertion failed");

`else

`define LDE_ASSERT_NOW(label, ante, cons)
`define LDE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/lde_pkg.sv
package lde_pkg;

   // field widths
   localparam int CHAN_W  = 8;
   localparam int LUMA_W  = 22;
   localparam int LINE_W  = 11;
   localparam int THR_W   = 18;
   localparam int IDX_W   = 2;
   localparam int DATA_W  = 11;

   // default line store depth
   localparam int MAX_LINE_WIDTH_DEF = 1024;

   // rec.709 weights scaled by 10000, threshold scale for ten percent
   localparam int COEF_R    = 2126;
   localparam int COEF_G    = 7152;
   localparam int COEF_B    = 722;
   localparam int THR_SCALE = 1000;

   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [LUMA_W-1:0] luma_type;
   typedef logic [IDX_W-1:0]  csr_index_type;
   typedef logic [DATA_W-1:0] csr_data_type;

   // register indexes
   localparam csr_index_type CSR_EDGE_MODE  = 2'd0;
   localparam csr_index_type CSR_MAX_COLOR  = 2'd1;
   localparam csr_index_type CSR_LINE_WIDTH = 2'd2;

   // reset values of the registers
   localparam logic              EDGE_MODE_RST  = 1'b0;
   localparam logic [CHAN_W-1:0] MAX_COLOR_RST  = 8'd255;
   localparam logic [LINE_W-1:0] LINE_WIDTH_RST = 11'd640;

endpackage

>>> rtl/lde_ifs.sv
// pixel word channel
interface lde_req_if;
   import lde_pkg::*;
   logic     valid;
   logic     ready;
   chan_type red;
   chan_type green;
   chan_type blue;
   logic     start_of_frame;

   modport source (output valid, output red, output green, output blue,
                   output start_of_frame, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input start_of_frame, output ready);
endinterface

// edge level word channel
interface lde_rsp_if;
   import lde_pkg::*;
   logic     valid;
   logic     ready;
   chan_type edge_level;

   modport source (output valid, output edge_level, input ready);
   modport sink   (input valid, input edge_level, output ready);
endinterface

// register write channel
interface lde_csr_if;
   import lde_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/lde_ram.sv
// simple dual port ram, registered read, read-first on an address clash
module lde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents when the write hits the same entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/luma_difference_edge_detector.sv
// Luma difference edge detector.
// Pixel words arrive on req_if (red, green, blue, start_of_frame) in raster
// order; one edge_level word per pixel leaves on rsp_if. Registers are set
// on csr_if (0 edge_mode, 1 max_color, 2 line_width), which is always ready
// and must only be written while the pipeline is empty.
// Each pixel is reduced to luma scaled by 10000 and compared with its left
// neighbour or, through a line store ram of MAX_LINE_WIDTH entries, with
// the pixel above. The output is max_color when the absolute difference is
// at least max_color*1000, else 0; the first column or row gives 0.
// Each accepted pixel is registered in stage one and then in the output stage,
// whose register drives the result word on rsp_if.
// Throughput: one pixel per clock while rsp_if is ready; the line store is read
// and written at the same entry in the accept cycle, so no interlock is needed.
// Reset: registers return to edge_mode 0, max_color 255, line_width 640,
// column and row tracking restart; the line store is not cleared and is
// filled by the first row of each image before it is read.
// When rsp_if stalls, the two stages hold their words and req_if.ready
// drops only once both stages are full.
`include "luma_difference_edge_detector_defines.svh"

module luma_difference_edge_detector #(
   parameter int MAX_LINE_WIDTH = lde_pkg::MAX_LINE_WIDTH_DEF
) (
   input logic   clock,
   input logic   reset,
   lde_req_if.sink   req_if,
   lde_rsp_if.source rsp_if,
   lde_csr_if.sink   csr_if
);
   import lde_pkg::*;

   localparam int CNT_W = $clog2(MAX_LINE_WIDTH);
   localparam int CMP_W = (CNT_W + 1 > LINE_W) ? CNT_W + 1 : LINE_W;
   localparam logic [CMP_W-1:0] MAX_WIDTH_C = CMP_W'(MAX_LINE_WIDTH);

   // configuration registers
   logic              edge_mode_ff;
   logic [CHAN_W-1:0] max_color_ff;
   logic [LINE_W-1:0] line_width_ff;

   // row tracking
   logic [CNT_W-1:0] column_count_ff, column_count_in;
   logic             first_row_ff, first_row_in;
   luma_type         left_luma_ff;

   // stage one and output stage
   logic        s1_valid_ff;
   logic        s1_mode_ff;
   logic        s1_cmp_en_ff;
   luma_type    s1_luma_ff;
   luma_type    s1_left_ff;
   logic        out_valid_ff;
   chan_type    edge_level_ff;

   logic        req_accept;
   logic        out_adv;
   logic [CNT_W-1:0] col;
   logic             frow;
   logic [CMP_W-1:0] lw_ext;
   logic [CMP_W-1:0] width_eff;
   logic [CMP_W-1:0] col_next;
   luma_type    luma;
   luma_type    above_luma;
   luma_type    operand;
   luma_type    diff;
   luma_type    thresh;
   chan_type    level;
   logic        cmp_en;

   // register writes
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_mode_ff  <= EDGE_MODE_RST;
         max_color_ff  <= MAX_COLOR_RST;
         line_width_ff <= LINE_WIDTH_RST;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_EDGE_MODE:  edge_mode_ff  <= csr_if.data[0];
            CSR_MAX_COLOR:  max_color_ff  <= csr_if.data[CHAN_W-1:0];
            CSR_LINE_WIDTH: line_width_ff <= csr_if.data[LINE_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign out_adv      = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = !s1_valid_ff || out_adv;
   assign req_accept   = req_if.valid && req_if.ready;

   // luma of the incoming pixel
   assign luma = LUMA_W'(COEF_R) * LUMA_W'(req_if.red)
               + LUMA_W'(COEF_G) * LUMA_W'(req_if.green)
               + LUMA_W'(COEF_B) * LUMA_W'(req_if.blue);

   // column and row position, clamped row width
   assign col    = req_if.start_of_frame ? '0 : column_count_ff;
   assign frow   = req_if.start_of_frame ? 1'b1 : first_row_ff;
   assign lw_ext = CMP_W'(line_width_ff);

   always_comb begin
      if (lw_ext == '0) begin
         width_eff = CMP_W'(1);
      end else if (lw_ext > MAX_WIDTH_C) begin
         width_eff = MAX_WIDTH_C;
      end else begin
         width_eff = lw_ext;
      end
   end

   assign col_next = CMP_W'(col) + CMP_W'(1);
   assign cmp_en   = edge_mode_ff ? !frow : (col != '0);

   always_comb begin
      column_count_in = column_count_ff;
      first_row_in    = first_row_ff;
      if (req_accept) begin
         if (col_next >= width_eff) begin
            column_count_in = '0;
            first_row_in    = 1'b0;
         end else begin
            column_count_in = col_next[CNT_W-1:0];
            first_row_in    = frow;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         first_row_ff    <= 1'b1;
         left_luma_ff    <= '0;
      end else begin
         column_count_ff <= column_count_in;
         first_row_ff    <= first_row_in;
         if (req_accept) begin
            left_luma_ff <= luma;
         end
      end
   end

   // line store: old entry read out while the new luma goes in
   lde_ram #(
      .WIDTH (LUMA_W),
      .DEPTH (MAX_LINE_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (req_accept),
      .wr_addr (col),
      .wr_data (luma),
      .rd_en   (req_accept),
      .rd_addr (col),
      .rd_data (above_luma)
   );

   // stage one control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         s1_valid_ff <= req_accept;
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mode_ff   <= edge_mode_ff;
         s1_cmp_en_ff <= cmp_en;
         s1_luma_ff   <= luma;
         s1_left_ff   <= left_luma_ff;
      end
   end

   // absolute difference against the threshold
   assign operand = s1_mode_ff ? above_luma : s1_left_ff;
   assign diff    = (s1_luma_ff >= operand) ? (s1_luma_ff - operand)
                                            : (operand - s1_luma_ff);
   assign thresh  = LUMA_W'(THR_W'(max_color_ff) * THR_W'(THR_SCALE));
   assign level   = (s1_cmp_en_ff && (diff >= thresh)) ? max_color_ff : '0;

   // output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_adv) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         edge_level_ff <= level;
      end
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.edge_level = edge_level_ff;

   // checks
   `LDE_ASSERT_NOW(a_level_legal, out_valid_ff, (edge_level_ff == '0) || (edge_level_ff == max_color_ff))
   `LDE_ASSERT_NEXT(a_accept_fills_s1, req_accept, s1_valid_ff)
   `LDE_ASSERT_NEXT(a_s1_held_on_stall, s1_valid_ff && !out_adv, s1_valid_ff && $stable(s1_luma_ff))
   `LDE_ASSERT_NEXT(a_rsp_held_on_stall, out_valid_ff && !rsp_if.ready, out_valid_ff && $stable(edge_level_ff))

endmodule
